[sv/aged_weight_normalizer_assert.svh]
// Assertion macros shared by the aged weight normalizer RTL.
`ifndef AGED_WEIGHT_NORMALIZER_ASSERT_SVH
`define AGED_WEIGHT_NORMALIZER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define AWN_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aged_weight_normalizer: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define AWN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aged_weight_normalizer: next-cycle check failed");
`else
`define AWN_ASSERT_IMPL(label, clk, rst, ante, cons)
`define AWN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/awn_pkg.sv]
// Shared constants, types and state encoding of the aged weight normalizer.
package awn_pkg;

   localparam int NUM_CELLS  = 4;
   localparam int TICK_BITS  = 32;
   localparam int FRAC_BITS  = 16;

   localparam int BIAS_W     = 16;
   localparam int SCORE_W    = 24;
   localparam int SOURCE_W   = 2;
   localparam int OUT_W      = 17;
   localparam int OUT_FIELDS = 4;

   localparam int WEIGHT_W   = FRAC_BITS + 1;
   localparam int CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int SUM_W      = WEIGHT_W + $clog2(NUM_CELLS);
   localparam int PROD_W     = BIAS_W + TICK_BITS;
   localparam int DEN_W      = PROD_W + 1;
   localparam int QUO_W      = WEIGHT_W;
   localparam int DVD_W      = WEIGHT_W + FRAC_BITS;
   localparam int MUL_CNT_W  = $clog2(BIAS_W + 1);
   localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

   localparam logic [BIAS_W-1:0]     AGE_BIAS_RESET = BIAS_W'(3277);
   localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE     = WEIGHT_W'(2 ** FRAC_BITS);
   localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET   = WEIGHT_W'((2 ** FRAC_BITS) / NUM_CELLS);
   localparam logic [TICK_BITS-1:0]  TICK_MAX       = {TICK_BITS{1'b1}};
   localparam logic [CELL_IDX_W-1:0] LAST_CELL      = CELL_IDX_W'(NUM_CELLS - 1);

   localparam logic FUNC_TICK    = 1'b0;
   localparam logic FUNC_OBSERVE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_AGE_DIV,
      ST_NORM_CHECK,
      ST_NORM_START,
      ST_NORM_DIV,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic                       func;
      logic [SOURCE_W-1:0]        source;
      logic signed [SCORE_W-1:0]  score;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] weight_zero;
      logic [OUT_W-1:0] weight_one;
      logic [OUT_W-1:0] weight_two;
      logic [OUT_W-1:0] weight_three;
   } rsp_type;

   typedef struct packed {
      logic start;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_sts_type;

endpackage

[sv/aged_weight_normalizer.sv]
// Top level of the aged weight normalizer: cell state, sequencer and result register.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/req_stall req_data  (func, source, score)
//   rsp      out        rsp_valid/rsp_stall rsp_data  (four cell weights)
//   csr      in         csr_valid/csr_ready csr_data  (age bias, Q16)
//
// An observation item is written into its cell at acceptance; the report state
// then loads its result into the output register and returns to idle, so the next
// item can be accepted while that result is presented. A tick item ages each cell
// in turn: a start state, the bit-serial multiplier and the bit-serial divider.
// The sum is then checked, and each cell is renormalized through the divider again
// unless every aged weight is zero.
// A synchronous reset restores the default weights, stamps, tick and bias.
// A new item is accepted while a finished result still waits in the output
// register; the next result is held back until that register is taken.
`include "aged_weight_normalizer_assert.svh"

module aged_weight_normalizer
   import awn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BIAS_W-1:0] csr_data
);

   state_type             state_ff, state_in;
   logic [CELL_IDX_W-1:0] cell_ff, cell_in;
   logic [TICK_BITS-1:0]  tick_ff, tick_in;
   logic [BIAS_W-1:0]     bias_ff, bias_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [WEIGHT_W-1:0]   weight_ff [NUM_CELLS];
   logic [WEIGHT_W-1:0]   weight_in [NUM_CELLS];
   logic [TICK_BITS-1:0]  stamp_ff [NUM_CELLS];
   logic [TICK_BITS-1:0]  stamp_in [NUM_CELLS];
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  rsp_free;
   logic [WEIGHT_W-1:0]   cur_weight;
   logic [TICK_BITS-1:0]  cur_stamp;
   logic [TICK_BITS-1:0]  cur_age;
   logic [DEN_W-1:0]      aging_den;
   logic [WEIGHT_W-1:0]   obs_weight;
   logic                  src_ok;
   logic [OUT_W-1:0]      out_w [OUT_FIELDS];

   unit_cmd_type          mul_cmd, div_cmd;
   unit_sts_type          mul_sts, div_sts;
   logic [PROD_W-1:0]     mul_product;
   logic [DVD_W-1:0]      div_dividend;
   logic [DEN_W-1:0]      div_divisor;
   logic [QUO_W-1:0]      div_quotient;

   // Items are taken only while the sequencer is idle; the result register
   // below decouples this from the output side.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // The cell under work is selected by the sequencer's cell counter.
   assign cur_weight = weight_ff[cell_ff];
   assign cur_stamp  = stamp_ff[cell_ff];
   assign cur_age    = (tick_ff >= cur_stamp) ? (tick_ff - cur_stamp) : '0;

   // The aging denominator is one plus bias times age, in the weight format.
   // Its largest value stays below the point where a cap would matter.
   assign aging_den  = DEN_W'(WEIGHT_ONE) + DEN_W'(mul_product);

   // A negative score clamps to zero and anything above one clamps to one.
   always_comb begin
      if (req_data.score[SCORE_W-1]) begin
         obs_weight = '0;
      end else if ({1'b0, $unsigned(req_data.score)} > (SCORE_W + 1)'(2 ** FRAC_BITS)) begin
         obs_weight = WEIGHT_ONE;
      end else begin
         obs_weight = WEIGHT_W'($unsigned(req_data.score));
      end
   end

   assign src_ok = (int'(req_data.source) < NUM_CELLS);

   // Both divisions shift the weight up by the fraction width.
   assign div_dividend = {cur_weight, {FRAC_BITS{1'b0}}};
   assign div_divisor  = (state_ff == ST_NORM_START) ? DEN_W'(sum_ff) : aging_den;

   assign mul_cmd.start = (state_ff == ST_MUL_START);
   assign div_cmd.start = ((state_ff == ST_MUL_WAIT) && mul_sts.done)
                       || (state_ff == ST_NORM_START);

   awn_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .age     (cur_age),
      .bias    (bias_ff),
      .sts     (mul_sts),
      .product (mul_product)
   );

   awn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .sts      (div_sts),
      .quotient (div_quotient)
   );

   // Sequencer. A tick ages cells one after another, keeps a running sum of
   // the aged weights, and then divides each weight by that sum unless it is
   // zero. An observation writes its cell at once and goes straight to report.
   always_comb begin
      state_in  = state_ff;
      cell_in   = cell_ff;
      tick_in   = tick_ff;
      sum_in    = sum_ff;
      weight_in = weight_ff;
      stamp_in  = stamp_ff;
      bias_in   = bias_ff;
      if (csr_valid && csr_ready) begin
         bias_in = csr_data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.func == FUNC_OBSERVE) begin
                  for (int c = 0; c < NUM_CELLS; c++) begin
                     if (src_ok && (int'(req_data.source) == c)) begin
                        weight_in[c] = obs_weight;
                        stamp_in[c]  = tick_ff;
                     end
                  end
                  state_in = ST_REPORT;
               end else begin
                  // The tick counter saturates at its top value.
                  if (tick_ff != TICK_MAX) begin
                     tick_in = tick_ff + TICK_BITS'(1);
                  end
                  cell_in  = '0;
                  sum_in   = '0;
                  state_in = ST_MUL_START;
               end
            end
         end
         ST_MUL_START: begin
            state_in = ST_MUL_WAIT;
         end
         ST_MUL_WAIT: begin
            if (mul_sts.done) begin
               state_in = ST_AGE_DIV;
            end
         end
         ST_AGE_DIV: begin
            if (div_sts.done) begin
               weight_in[cell_ff] = div_quotient;
               sum_in = sum_ff + SUM_W'(div_quotient);
               if (cell_ff == LAST_CELL) begin
                  state_in = ST_NORM_CHECK;
               end else begin
                  cell_in  = cell_ff + CELL_IDX_W'(1);
                  state_in = ST_MUL_START;
               end
            end
         end
         ST_NORM_CHECK: begin
            // With every aged weight at zero the weights are left as they are.
            if (sum_ff == '0) begin
               state_in = ST_REPORT;
            end else begin
               cell_in  = '0;
               state_in = ST_NORM_START;
            end
         end
         ST_NORM_START: begin
            state_in = ST_NORM_DIV;
         end
         ST_NORM_DIV: begin
            if (div_sts.done) begin
               weight_in[cell_ff] = div_quotient;
               if (cell_ff == LAST_CELL) begin
                  state_in = ST_REPORT;
               end else begin
                  cell_in  = cell_ff + CELL_IDX_W'(1);
                  state_in = ST_NORM_START;
               end
            end
         end
         ST_REPORT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Every item reports the weights of the first four cells; a field with
   // no cell behind it reads as zero.
   always_comb begin
      for (int j = 0; j < OUT_FIELDS; j++) begin
         if (j < NUM_CELLS) begin
            out_w[j] = OUT_W'(weight_ff[CELL_IDX_W'(j)]);
         end else begin
            out_w[j] = '0;
         end
      end
   end

   // Output register: loaded from the report state when it is free, and
   // emptied when the downstream side takes the item.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == ST_REPORT) && rsp_free) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.weight_zero  = out_w[0];
         rsp_data_in.weight_one   = out_w[1];
         rsp_data_in.weight_two   = out_w[2];
         rsp_data_in.weight_three = out_w[3];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cell_ff      <= '0;
         tick_ff      <= '0;
         bias_ff      <= AGE_BIAS_RESET;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CELLS; c++) begin
            weight_ff[c] <= WEIGHT_RESET;
            stamp_ff[c]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cell_ff      <= cell_in;
         tick_ff      <= tick_in;
         bias_ff      <= bias_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         weight_ff    <= weight_in;
         stamp_ff     <= stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The multiplier only runs while the sequencer waits for it.
   `AWN_ASSERT_IMPL(a_mul_busy_state, clock, reset, mul_sts.busy, state_ff == ST_MUL_WAIT)
   // The divider only runs during an aging or a renormalizing division.
   `AWN_ASSERT_IMPL(a_div_busy_state, clock, reset, div_sts.busy, (state_ff == ST_AGE_DIV) || (state_ff == ST_NORM_DIV))
   // The tick counter never moves backward.
   `AWN_ASSERT_NEXT(a_tick_monotonic, clock, reset, 1'b1, tick_ff >= $past(tick_ff))
   // Leaving the report state always presents a result.
   `AWN_ASSERT_NEXT(a_report_loads, clock, reset, (state_ff == ST_REPORT) && rsp_free, rsp_valid_ff)

endmodule

[sv/awn_mul.sv]
// Bit-serial shift-add multiplier for the aging term bias times age.
module awn_mul
   import awn_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  unit_cmd_type         cmd,
   input  logic [TICK_BITS-1:0] age,
   input  logic [BIAS_W-1:0]    bias,
   output unit_sts_type         sts,
   output logic [PROD_W-1:0]    product
);

   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [TICK_BITS-1:0] mcand_ff, mcand_in;
   logic [BIAS_W-1:0]    mplr_ff, mplr_in;

   // The bias bits are consumed most significant first, one per cycle.
   always_comb begin
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mplr_in  = mplr_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         cnt_in   = MUL_CNT_W'(BIAS_W);
         acc_in   = '0;
         mcand_in = age;
         mplr_in  = bias;
      end else if (cnt_ff != '0) begin
         acc_in  = {acc_ff[PROD_W-2:0], 1'b0}
                 + (mplr_ff[BIAS_W-1] ? PROD_W'(mcand_ff) : '0);
         mplr_in = {mplr_ff[BIAS_W-2:0], 1'b0};
         cnt_in  = cnt_ff - MUL_CNT_W'(1);
         done_in = (cnt_ff == MUL_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      mplr_ff  <= mplr_in;
   end

   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
   assign product  = acc_ff;

endmodule

[sv/awn_div.sv]
// Bit-serial restoring divider that yields one quotient bit per cycle.
module awn_div
   import awn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  unit_cmd_type      cmd,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [DEN_W-1:0]  divisor,
   output unit_sts_type      sts,
   output logic [QUO_W-1:0]  quotient
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DEN_W-1:0]     dsr_ff, dsr_in;
   logic [QUO_W-1:0]     low_ff, low_in;
   logic [QUO_W-1:0]     quo_ff, quo_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 fits;

   // The upper dividend bits are always below the divisor, so only the low
   // QUO_W bits can produce quotient bits and the rest are preloaded.
   always_comb begin
      trial   = {rem_ff, low_ff[QUO_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      fits    = (trial >= {1'b0, dsr_ff});
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         cnt_in = DIV_CNT_W'(QUO_W);
         rem_in = DEN_W'(dividend[DVD_W-1:QUO_W]);
         low_in = dividend[QUO_W-1:0];
         dsr_in = divisor;
         quo_in = '0;
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         low_in  = {low_ff[QUO_W-2:0], 1'b0};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         done_in = (cnt_ff == DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule
